// ===== rtl/eds_pkg.sv =====
package eds_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int TIME_WIDTH = 32;

    typedef enum logic [2:0] {
        ACT_SCHED_REL  = 3'd0,
        ACT_SCHED_ABS  = 3'd1,
        ACT_REMOVE     = 3'd2,
        ACT_REMOVE_GRP = 3'd3,
        ACT_SET_SPEED  = 3'd4,
        ACT_ADVANCE    = 3'd5,
        ACT_POP        = 3'd6,
        ACT_TURNAROUND = 3'd7
    } action_t;

    localparam logic [0:0] REG_FRAME_LENGTH = 1'd0;
    localparam logic [0:0] REG_LAST_SCALED  = 1'd1;

    localparam logic [15:0] FRAME_RESET = 16'd17556;
    localparam logic [3:0]  GROUP_RESET = 4'd3;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

endpackage

// ===== rtl/event_deadline_scheduler.sv =====
// Channel   | Dir | Beat contents (low bit first)
// s_axis    | in  | tdata: action[2:0] event_slot[6:3] cycle_value[38:7] speed_flag[39]
// m_axis    | out | tdata: popped_valid, popped_slot, popped_time, next_valid, next_slot,
//           |     |        next_time, missed_count, refused (88 bits)
// cfg       | in  | cfg_we, cfg_index (0 frame_length, 1 last_scaled_slot), cfg_data
//
// A beat first does flag/time updates (ST_READ), then a read-modify-write sweep of the
// deadline memory (one slot per cycle, registered read) that also searches for the
// earliest deadline, then ST_DRAIN and an output load (ST_OUT). A pop sweeps twice
// when the first sweep finds a winner (search, then search without the winner).
// Valid and count-written bits are flip-flops cleared by rst_n, so a count never
// written reads as zero. A result waits in the output register until taken, and no
// new beat is accepted while it waits.
module event_deadline_scheduler
    import eds_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // action, event_slot, cycle_value, speed_flag
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [87:0]  m_axis_tdata,   // popped_valid..refused, see table above
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = SW + 1;
    localparam int TW = TIME_WIDTH;

    logic [TW-1:0] dl_mem [NUM_SLOTS];
    logic [TW-1:0] rc_mem [NUM_SLOTS];
    logic [TW-1:0] dl_rd, rc_rd;

    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_SLOTS-1:0] rc_set_reg, rc_set_next;  // kept count written at least once
    logic [TW-1:0] now_reg, now_next;
    logic dbl_reg, dbl_next;
    logic [15:0] frame_reg;
    logic [3:0]  group_reg;
    state_t state_reg, state_next;

    action_t act_reg;
    logic [3:0] slot_reg;
    logic [TW-1:0] val_reg;
    logic flag_reg;

    logic [CW-1:0] idx_reg, idx_next;     // read address counter
    logic [SW-1:0] prc_reg, prc_next;     // slot whose data arrives now
    logic prc_vld_reg, prc_vld_next;

    logic best_vld_reg, best_vld_next;
    logic [SW-1:0] best_slot_reg, best_slot_next;
    logic [TW-1:0] best_time_reg, best_time_next;
    logic pop_phase_reg, pop_phase_next;  // pop: first pass searches only
    logic pv_reg, pv_next;
    logic [SW-1:0] ps_reg, ps_next;
    logic [TW-1:0] pt_reg, pt_next;
    logic [4:0] missed_reg, missed_next;
    logic refused_reg, refused_next;
    logic [87:0] out_reg, out_next;
    logic out_vld_reg, out_vld_next;

    logic wr_en;
    logic [SW-1:0] wr_addr;
    logic [TW-1:0] wr_dl, wr_rc;
    logic wr_rc_en;

    logic [SW-1:0] rd_addr;
    logic [3:0] top;
    logic [TW-1:0] frame;
    logic in_range;

    assign rd_addr = idx_reg[SW-1:0];
    assign in_range = ({1'b0, slot_reg} < 5'(NUM_SLOTS));
    assign top = (32'(group_reg) >= NUM_SLOTS) ? 4'(NUM_SLOTS - 1) : group_reg;
    assign frame = dbl_reg ? TW'({frame_reg, 1'b0}) : TW'(frame_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dl_mem[wr_addr] <= wr_dl;
            if (wr_rc_en)
                rc_mem[wr_addr] <= wr_rc;
        end
        dl_rd <= dl_mem[rd_addr];
        rc_rd <= rc_mem[rd_addr];
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_vld_reg;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

    always_comb
    begin
        logic [TW-1:0] d;
        logic [TW-1:0] span;
        logic [TW-1:0] rc;
        logic is_tgt, low, v;
        state_next = state_reg;
        valid_next = valid_reg;
        rc_set_next = rc_set_reg;
        now_next = now_reg;
        dbl_next = dbl_reg;
        idx_next = idx_reg;
        prc_next = prc_reg;
        prc_vld_next = 1'b0;
        best_vld_next = best_vld_reg;
        best_slot_next = best_slot_reg;
        best_time_next = best_time_reg;
        pop_phase_next = pop_phase_reg;
        pv_next = pv_reg;
        ps_next = ps_reg;
        pt_next = pt_reg;
        missed_next = missed_reg;
        refused_next = refused_reg;
        out_next = out_reg;
        out_vld_next = out_vld_reg;
        wr_en = 1'b0;
        wr_rc_en = 1'b0;
        wr_addr = prc_reg;
        wr_dl = dl_rd;
        wr_rc = val_reg;
        d = dl_rd;
        span = '0;
        rc = '0;
        is_tgt = 1'b0;
        low = 1'b0;
        v = 1'b0;

        if (out_vld_reg && m_axis_tready)
            out_vld_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                best_vld_next = 1'b0;
                pop_phase_next = 1'b0;
                pv_next = 1'b0;
                ps_next = '0;
                pt_next = '0;
                missed_next = '0;
                refused_next = 1'b0;
                if (s_axis_tvalid && s_axis_tready)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                // Pre-sweep actions that touch only flags or time.
                case (act_reg)
                    ACT_SCHED_REL, ACT_SCHED_ABS:
                        if (in_range && valid_reg[slot_reg[SW-1:0]])
                            refused_next = 1'b1;
                    ACT_REMOVE:
                        if (in_range)
                            valid_next[slot_reg[SW-1:0]] = 1'b0;
                    ACT_REMOVE_GRP:
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (4'(i) <= top)
                                valid_next[i] = 1'b0;
                    ACT_ADVANCE:
                        now_next = now_reg + val_reg;
                    ACT_TURNAROUND:
                        now_next = now_reg - frame;
                    default: ;
                endcase
                state_next = ST_SCAN;
            end
            ST_SCAN, ST_DRAIN:
            begin
                if (state_reg == ST_SCAN)
                begin
                    prc_next = rd_addr;
                    prc_vld_next = 1'b1;
                    idx_next = idx_reg + CW'(1);
                    if (idx_reg == CW'(NUM_SLOTS - 1))
                        state_next = ST_DRAIN;
                end
                if (prc_vld_reg)
                begin
                    v = valid_reg[prc_reg];
                    low = (4'(prc_reg) <= top);
                    rc = rc_set_reg[prc_reg] ? rc_rd : '0;
                    is_tgt = in_range && (slot_reg[SW-1:0] == prc_reg)
                             && (32'(slot_reg) < NUM_SLOTS);
                    if (!pop_phase_reg || act_reg != ACT_POP)
                    begin
                        case (act_reg)
                            ACT_SCHED_REL, ACT_SCHED_ABS:
                                if (is_tgt && !refused_reg)
                                begin
                                    if (act_reg == ACT_SCHED_REL)
                                    begin
                                        span = (dbl_reg && low) ? (val_reg << 1) : val_reg;
                                        d = now_reg + span;
                                        wr_rc_en = 1'b1;
                                        rc_set_next[prc_reg] = 1'b1;
                                    end
                                    else
                                        d = val_reg;
                                    wr_en = 1'b1;
                                    v = 1'b1;
                                    valid_next[prc_reg] = 1'b1;
                                end
                            ACT_SET_SPEED:
                                if (v && low)
                                begin
                                    d = flag_reg ? dl_rd + rc : dl_rd - rc;
                                    wr_en = 1'b1;
                                end
                            ACT_TURNAROUND:
                                if (v)
                                begin
                                    if (dl_rd > frame)
                                    begin
                                        d = dl_rd - frame;
                                        wr_en = 1'b1;
                                    end
                                    else if (missed_reg != 5'd31)
                                        missed_next = missed_reg + 5'd1;
                                end
                            default: ;
                        endcase
                    end
                    else if (pv_reg && prc_reg == ps_reg)
                        v = 1'b0;
                    wr_dl = d;
                    if (v && (!best_vld_next || d < best_time_next))
                    begin
                        best_vld_next = 1'b1;
                        best_slot_next = prc_reg;
                        best_time_next = d;
                    end
                end
                if (state_reg == ST_DRAIN)
                begin
                    if (act_reg == ACT_POP && !pop_phase_reg && best_vld_next)
                    begin
                        // Remove the winner and search again.
                        pv_next = 1'b1;
                        ps_next = best_slot_next;
                        pt_next = best_time_next;
                        valid_next[best_slot_next] = 1'b0;
                        pop_phase_next = 1'b1;
                        best_vld_next = 1'b0;
                        idx_next = '0;
                        state_next = ST_SCAN;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_next = {8'd0, refused_reg, missed_reg,
                            32'(best_vld_reg ? best_time_reg : '0),
                            4'(best_vld_reg ? best_slot_reg : '0), best_vld_reg,
                            32'(pt_reg), 4'(ps_reg), pv_reg};
                out_vld_next = 1'b1;
                if (act_reg == ACT_SET_SPEED)
                    dbl_next = flag_reg;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            rc_set_reg <= '0;
            now_reg <= '0;
            dbl_reg <= 1'b0;
            frame_reg <= FRAME_RESET;
            group_reg <= GROUP_RESET;
            out_vld_reg <= 1'b0;
            prc_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            rc_set_reg <= rc_set_next;
            now_reg <= now_next;
            dbl_reg <= dbl_next;
            out_vld_reg <= out_vld_next;
            prc_vld_reg <= prc_vld_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_FRAME_LENGTH)
                    frame_reg <= cfg_data;
                else
                    group_reg <= cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            act_reg <= action_t'(s_axis_tdata[2:0]);
            slot_reg <= s_axis_tdata[6:3];
            val_reg <= TW'(s_axis_tdata[38:7]);
            flag_reg <= s_axis_tdata[39];
        end
        idx_reg <= idx_next;
        prc_reg <= prc_next;
        best_vld_reg <= best_vld_next;
        best_slot_reg <= best_slot_next;
        best_time_reg <= best_time_next;
        pop_phase_reg <= pop_phase_next;
        pv_reg <= pv_next;
        ps_reg <= ps_next;
        pt_reg <= pt_next;
        missed_reg <= missed_next;
        refused_reg <= refused_next;
        out_reg <= out_next;
    end

endmodule
